### src/owr_pkg.sv
// Shared types and constants for the orthogonal wire router.
// No dependencies; every other file but owr_checker imports this package.
`default_nettype none

package owr_pkg;

	localparam int InW    = 20;          // pin coordinate width
	localparam int PtW    = 21;          // vertex coordinate width
	localparam int ZoomW  = 16;          // zoom register width
	localparam int StubW  = 13;          // stub and radius cap width
	localparam int OffW   = 14;          // signed corner offset width
	localparam int NPts   = 6;           // start, four corner slots, end
	localparam int NCor   = 4;           // corner slots
	localparam int NArc   = 5;           // vertices of one rounded corner
	localparam int LevelTol = 24;        // 1.5 with 4 fraction bits
	localparam int RadMin   = 32;        // 1.0 with 5 fraction bits

	localparam int RegZoom = 0;          // register index of zoom
	localparam logic [ZoomW-1:0] ZoomReset = 16'd4096;

	typedef logic signed [PtW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef enum logic [1:0] {
		ROUTE_STRAIGHT,
		ROUTE_ELBOW,
		ROUTE_DETOUR
	} route_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} adv_t;

endpackage

`default_nettype wire

### src/orthogonal_wire_router_unit.sv
// Top level of the orthogonal wire router: config register, pipeline control.
// Depends on owr_pkg, owr_route, owr_geom and owr_serial.
//
// One wire enters per beat on the input channel and leaves as a polyline of
// 2 to 22 vertex beats, the final one flagged by last. Straight wires give 2
// beats, elbows 4 to 12, detours 6 to 22 (one per sharp corner, five per
// rounded one). Three pipeline stages (route, radius, arc points) lead into
// an output buffer that sends one vertex per cycle while out_ready is high;
// the input takes a new wire every cycle while the pipeline has room. The
// first vertex of a wire is presented once it has passed the route, radius
// and arc-point registers and has been loaded into the output buffer. The
// zoom register sits at byte address 0 and must only be written while no
// wire is in flight; a wire may follow the write in the very next cycle.
`default_nettype none

module orthogonal_wire_router_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [19:0] start_x,
	input  wire logic signed [19:0] start_y,
	input  wire logic signed [19:0] end_x,
	input  wire logic signed [19:0] end_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [20:0]      point_x,
	output logic signed [20:0]      point_y,
	output logic                    last
);
	import owr_pkg::*;

	localparam logic [StubW-1:0] StubReset = StubW'((32'(ZoomReset) * 14 + 128) >> 8);
	localparam logic [StubW-1:0] RcapReset = StubW'((32'(ZoomReset) * 10 + 64) >> 7);

	logic [ZoomW-1:0] zoom_q;
	logic [StubW-1:0] stub_q, rcap_q;
	logic [20:0] stub_w;
	logic [19:0] rcap_w;
	logic v1_q, v2_q, v3_q;
	logic rdy1, rdy2, rdy3, load_ready;
	adv_t adv;

	pt_t [NPts-1:0] pts_s1;
	route_t route_s1, route_s3;
	pt_t start_s3, end_s3;
	pt_t [NCor-1:0][NArc-1:0] arc_s3;
	logic [NCor-1:0] sharp_s3;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'(RegZoom)) ? {16'b0, zoom_q} : 32'b0;

	// 14*zoom and 10*zoom of the written value, rounded to 4 and 5 fraction bits
	always_comb begin
		stub_w = 21'(pwdata[ZoomW-1:0]) * 21'd14 + 21'd128;
		rcap_w = 20'(pwdata[ZoomW-1:0]) * 20'd10 + 20'd64;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q <= ZoomReset;
			stub_q <= StubReset;
			rcap_q <= RcapReset;
		end else if (psel && penable && pwrite && paddr[2] == 1'(RegZoom)) begin
			zoom_q <= pwdata[ZoomW-1:0];
			stub_q <= stub_w[20:8];
			rcap_q <= rcap_w[19:7];
		end
	end

	always_comb begin
		rdy3     = !v3_q || load_ready;
		rdy2     = !v2_q || rdy3;
		rdy1     = !v1_q || rdy2;
		in_ready = rdy1;
		adv.s2   = rdy2;
		adv.s3   = rdy3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	owr_route u_route (
		.clk      (clk),
		.en       (rdy1),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.stub     (stub_q),
		.pts_s1   (pts_s1),
		.route_s1 (route_s1)
	);

	owr_geom u_geom (
		.clk      (clk),
		.adv      (adv),
		.pts_s1   (pts_s1),
		.route_s1 (route_s1),
		.rcap     (rcap_q),
		.start_s3 (start_s3),
		.end_s3   (end_s3),
		.arc_s3   (arc_s3),
		.sharp_s3 (sharp_s3),
		.route_s3 (route_s3)
	);

	owr_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v3_q),
		.load_ready (load_ready),
		.start_s3   (start_s3),
		.end_s3     (end_s3),
		.arc_s3     (arc_s3),
		.sharp_s3   (sharp_s3),
		.route_s3   (route_s3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.last       (last)
	);

endmodule

`default_nettype wire

### src/owr_route.sv
// First pipeline stage: classify the wire and place its corner points.
// Depends on owr_pkg.
`default_nettype none

module owr_route (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [19:0]      start_x,
	input  wire logic signed [19:0]      start_y,
	input  wire logic signed [19:0]      end_x,
	input  wire logic signed [19:0]      end_y,
	input  wire logic [owr_pkg::StubW-1:0] stub,
	output owr_pkg::pt_t [owr_pkg::NPts-1:0] pts_s1,
	output owr_pkg::route_t              route_s1
);
	import owr_pkg::*;

	coord_t sx, sy, ex, ey, dy, gap, stub_c, stub2_c, sum_x, sum_y, mx, my;
	pt_t [NPts-1:0] pts;
	route_t route;

	always_comb begin
		sx      = {start_x[19], start_x};
		sy      = {start_y[19], start_y};
		ex      = {end_x[19], end_x};
		ey      = {end_y[19], end_y};
		dy      = sy - ey;
		gap     = ex - sx;
		stub_c  = {8'b0, stub};
		stub2_c = {7'b0, stub, 1'b0};
		sum_x   = sx + ex;
		sum_y   = sy + ey;
		mx      = sum_x >>> 1;
		my      = sum_y >>> 1;
		// unused trailing slots repeat the end point
		for (int i = 0; i < NPts; i++) begin
			pts[i].x = ex;
			pts[i].y = ey;
		end
		pts[0].x = sx;
		pts[0].y = sy;
		if (dy <= coord_t'(LevelTol) && dy >= -coord_t'(LevelTol) && ex >= sx) begin
			route = ROUTE_STRAIGHT;
		end else if (gap >= stub2_c) begin
			route = ROUTE_ELBOW;
			pts[1].x = mx;
			pts[1].y = sy;
			pts[2].x = mx;
			pts[2].y = ey;
		end else begin
			route = ROUTE_DETOUR;
			pts[1].x = sx + stub_c;
			pts[1].y = sy;
			pts[2].x = sx + stub_c;
			pts[2].y = my;
			pts[3].x = ex - stub_c;
			pts[3].y = my;
			pts[4].x = ex - stub_c;
			pts[4].y = ey;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s1   <= pts;
			route_s1 <= route;
		end
	end

endmodule

`default_nettype wire

### src/owr_geom.sv
// Second and third pipeline stages: corner radius, then arc and Bezier vertices.
// Depends on owr_pkg.
`default_nettype none

module owr_geom (
	input  wire logic                          clk,
	input  wire owr_pkg::adv_t                 adv,
	input  wire owr_pkg::pt_t [owr_pkg::NPts-1:0] pts_s1,
	input  wire owr_pkg::route_t               route_s1,
	input  wire logic [owr_pkg::StubW-1:0]     rcap,
	output owr_pkg::pt_t                       start_s3,
	output owr_pkg::pt_t                       end_s3,
	output owr_pkg::pt_t [owr_pkg::NCor-1:0][owr_pkg::NArc-1:0] arc_s3,
	output logic [owr_pkg::NCor-1:0]           sharp_s3,
	output owr_pkg::route_t                    route_s3
);
	import owr_pkg::*;

	typedef logic signed [OffW-1:0] off_t;

	localparam logic signed [18:0] WHi  = 19'sd9;
	localparam logic signed [18:0] WMid = 19'sd4;
	localparam logic signed [18:0] WLo  = 19'sd1;

	function automatic coord_t half_off(coord_t c, off_t d);
		logic signed [OffW:0] t;
		t = {d[OffW-1], d} + (OffW+1)'(1);
		return c + {{(PtW-OffW){t[OffW]}}, t[OffW:1]};
	endfunction

	function automatic coord_t bez_off(coord_t c, off_t da, off_t de,
			logic signed [18:0] wa, logic signed [18:0] we);
		logic signed [18:0] s;
		s = wa * {{5{da[OffW-1]}}, da} + we * {{5{de[OffW-1]}}, de} + 19'sd16;
		return c + {{(PtW-OffW){s[18]}}, s[18:5]};
	endfunction

	function automatic logic [21:0] mag(logic signed [21:0] d);
		return d[21] ? 22'(-d) : 22'(d);
	endfunction

	// stage 2 signals
	logic signed [21:0] dix [NCor];
	logic signed [21:0] diy [NCor];
	logic signed [21:0] dox [NCor];
	logic signed [21:0] doy [NCor];
	logic [22:0] li [NCor];
	logic [22:0] lo [NCor];
	logic [StubW-1:0] r [NCor];
	off_t rs [NCor];
	off_t dax [NCor];
	off_t day [NCor];
	off_t dex [NCor];
	off_t dey [NCor];

	pt_t [NCor-1:0] c_s2;
	off_t dax_s2 [NCor];
	off_t day_s2 [NCor];
	off_t dex_s2 [NCor];
	off_t dey_s2 [NCor];
	logic [NCor-1:0] sharp_s2;
	pt_t start_s2, end_s2;
	route_t route_s2;

	pt_t [NCor-1:0][NArc-1:0] arc;

	always_comb begin
		for (int i = 0; i < NCor; i++) begin
			dix[i] = {pts_s1[i+1].x[PtW-1], pts_s1[i+1].x} - {pts_s1[i].x[PtW-1], pts_s1[i].x};
			diy[i] = {pts_s1[i+1].y[PtW-1], pts_s1[i+1].y} - {pts_s1[i].y[PtW-1], pts_s1[i].y};
			dox[i] = {pts_s1[i+2].x[PtW-1], pts_s1[i+2].x} - {pts_s1[i+1].x[PtW-1], pts_s1[i+1].x};
			doy[i] = {pts_s1[i+2].y[PtW-1], pts_s1[i+2].y} - {pts_s1[i+1].y[PtW-1], pts_s1[i+1].y};
			li[i]  = {1'b0, mag(dix[i])} + {1'b0, mag(diy[i])};
			lo[i]  = {1'b0, mag(dox[i])} + {1'b0, mag(doy[i])};
			r[i]   = rcap;
			if (li[i] < {10'b0, r[i]}) begin
				r[i] = li[i][StubW-1:0];
			end
			if (lo[i] < {10'b0, r[i]}) begin
				r[i] = lo[i][StubW-1:0];
			end
			rs[i]  = {1'b0, r[i]};
			// arc start steps back along the incoming leg, end steps out along the outgoing
			dax[i] = dix[i] > 0 ? -rs[i] : (dix[i] < 0 ? rs[i] : '0);
			day[i] = diy[i] > 0 ? -rs[i] : (diy[i] < 0 ? rs[i] : '0);
			dex[i] = dox[i] > 0 ? rs[i] : (dox[i] < 0 ? -rs[i] : '0);
			dey[i] = doy[i] > 0 ? rs[i] : (doy[i] < 0 ? -rs[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int i = 0; i < NCor; i++) begin
				c_s2[i]     <= pts_s1[i+1];
				dax_s2[i]   <= dax[i];
				day_s2[i]   <= day[i];
				dex_s2[i]   <= dex[i];
				dey_s2[i]   <= dey[i];
				sharp_s2[i] <= r[i] < StubW'(RadMin);
			end
			start_s2 <= pts_s1[0];
			end_s2   <= pts_s1[NPts-1];
			route_s2 <= route_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < NCor; i++) begin
			arc[i][0].x = half_off(c_s2[i].x, dax_s2[i]);
			arc[i][0].y = half_off(c_s2[i].y, day_s2[i]);
			arc[i][1].x = bez_off(c_s2[i].x, dax_s2[i], dex_s2[i], WHi, WLo);
			arc[i][1].y = bez_off(c_s2[i].y, day_s2[i], dey_s2[i], WHi, WLo);
			arc[i][2].x = bez_off(c_s2[i].x, dax_s2[i], dex_s2[i], WMid, WMid);
			arc[i][2].y = bez_off(c_s2[i].y, day_s2[i], dey_s2[i], WMid, WMid);
			arc[i][3].x = bez_off(c_s2[i].x, dax_s2[i], dex_s2[i], WLo, WHi);
			arc[i][3].y = bez_off(c_s2[i].y, day_s2[i], dey_s2[i], WLo, WHi);
			arc[i][4].x = half_off(c_s2[i].x, dex_s2[i]);
			arc[i][4].y = half_off(c_s2[i].y, dey_s2[i]);
			// keep the sharp corner when the radius is too small
			if (sharp_s2[i]) begin
				arc[i][0] = c_s2[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			arc_s3   <= arc;
			sharp_s3 <= sharp_s2;
			start_s3 <= start_s2;
			end_s3   <= end_s2;
			route_s3 <= route_s2;
		end
	end

endmodule

`default_nettype wire

### src/owr_serial.sv
// Output buffer: holds one wire's vertices and sends them one beat per cycle while out_ready is high.
// Depends on owr_pkg.
`default_nettype none

module owr_serial (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load_valid,
	output logic                               load_ready,
	input  wire owr_pkg::pt_t                  start_s3,
	input  wire owr_pkg::pt_t                  end_s3,
	input  wire owr_pkg::pt_t [owr_pkg::NCor-1:0][owr_pkg::NArc-1:0] arc_s3,
	input  wire logic [owr_pkg::NCor-1:0]      sharp_s3,
	input  wire owr_pkg::route_t               route_s3,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [owr_pkg::PtW-1:0]     point_x,
	output logic signed [owr_pkg::PtW-1:0]     point_y,
	output logic                               last
);
	import owr_pkg::*;

	localparam logic [2:0] GrpStart = 3'd0;
	localparam logic [2:0] GrpEnd   = 3'(NPts-1);

	pt_t buf_q [NPts][NArc];
	logic [NPts-1:0] sharp_q;
	route_t route_q;
	logic [2:0] g_q, k_q;
	logic busy_q;

	logic [2:0] ncor, g_next, gsize;
	logic take, fin;

	always_comb begin
		case (route_q)
			ROUTE_STRAIGHT: ncor = 3'd0;
			ROUTE_ELBOW:    ncor = 3'd2;
			ROUTE_DETOUR:   ncor = 3'd4;
			default:        ncor = 3'd0;
		endcase
		gsize  = sharp_q[g_q] ? 3'd1 : 3'(NArc);
		g_next = (g_q >= ncor) ? GrpEnd : g_q + 3'd1;
		fin    = out_ready && (g_q == GrpEnd);
		load_ready = !busy_q || fin;
		take   = load_valid && load_ready;
		out_valid = busy_q;
		point_x = buf_q[g_q][k_q].x;
		point_y = buf_q[g_q][k_q].y;
		last    = (g_q == GrpEnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			g_q    <= GrpStart;
			k_q    <= 3'd0;
		end else if (take) begin
			busy_q <= 1'b1;
			g_q    <= GrpStart;
			k_q    <= 3'd0;
		end else if (busy_q && out_ready) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else if (k_q + 3'd1 < gsize) begin
				k_q <= k_q + 3'd1;
			end else begin
				k_q <= 3'd0;
				g_q <= g_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q[0][0]      <= start_s3;
			buf_q[NPts-1][0] <= end_s3;
			for (int i = 0; i < NCor; i++) begin
				for (int k = 0; k < NArc; k++) begin
					buf_q[i+1][k] <= arc_s3[i][k];
				end
			end
			// start and end are single-vertex groups
			sharp_q <= {1'b1, sharp_s3, 1'b1};
			route_q <= route_s3;
		end
	end

endmodule

`default_nettype wire

### src/owr_checker.sv
// Port-level checks for the orthogonal wire router, bound to the top level.
// Depends on orthogonal_wire_router_unit.
`default_nettype none

module owr_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [20:0] point_x,
	input wire logic signed [20:0] point_y,
	input wire logic               last
);

	// a stalled vertex beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(last))
		else $error("stalled output beat changed");

	// vertices of one wire leave without gaps
	a_wire_contig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a wire");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind orthogonal_wire_router_unit owr_checker u_owr_checker (.*);

`default_nettype wire

### tb/orthogonal_wire_router_unit_tb.sv
// Self-checking testbench for the orthogonal wire router: drives wires and zoom
// settings, predicts each polyline in a scoreboard class and checks every vertex.
// Depends on owr_pkg and orthogonal_wire_router_unit.
`timescale 1ns / 1ps

module orthogonal_wire_router_unit_tb;
	import owr_pkg::*;

	typedef struct {
		logic signed [20:0] x;
		logic signed [20:0] y;
		logic               lst;
	} vertex_t;

	class polyline_scoreboard;
		vertex_t     pending[$];
		int unsigned zoom;
		int          errors;
		int          wires;
		int          vertices;

		function new();
			zoom = ZoomReset;
		endfunction

		function longint fshift(longint v, int s);
			return v >>> s;
		endfunction

		function void push_vertex(longint x, longint y);
			vertex_t v;
			v.x = x[20:0];
			v.y = y[20:0];
			v.lst = 1'b0;
			pending.push_back(v);
		endfunction

		function longint sgn(longint v);
			return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
		endfunction

		// Route the wire, then round each interior corner.
		function void note_wire(longint sx, longint sy, longint ex, longint ey);
			longint cx[6], cy[6];
			longint stub, rcap, mx, my, dix, diy, dox, doy, li, lo, r;
			longint c2x, c2y, a2x, a2y, e2x, e2y, bx, by;
			longint w0[3], w1[3], w2[3];
			int nc, i, k;
			vertex_t v;
			w0 = '{9, 4, 1};
			w1 = '{6, 8, 6};
			w2 = '{1, 4, 9};
			stub = (14 * longint'(zoom) + 128) >> 8;
			rcap = (10 * longint'(zoom) + 64) >> 7;
			nc = 0;
			cx[nc] = sx; cy[nc] = sy; nc++;
			if ((sy - ey <= 24 && ey - sy <= 24) && ex >= sx) begin
			end else if (ex - sx >= 2 * stub) begin
				mx = fshift(sx + ex, 1);
				cx[nc] = mx; cy[nc] = sy; nc++;
				cx[nc] = mx; cy[nc] = ey; nc++;
			end else begin
				my = fshift(sy + ey, 1);
				cx[nc] = sx + stub; cy[nc] = sy; nc++;
				cx[nc] = sx + stub; cy[nc] = my; nc++;
				cx[nc] = ex - stub; cy[nc] = my; nc++;
				cx[nc] = ex - stub; cy[nc] = ey; nc++;
			end
			cx[nc] = ex; cy[nc] = ey; nc++;
			push_vertex(cx[0], cy[0]);
			for (i = 1; i < nc - 1; i++) begin
				dix = cx[i] - cx[i-1]; diy = cy[i] - cy[i-1];
				dox = cx[i+1] - cx[i]; doy = cy[i+1] - cy[i];
				li = (dix < 0 ? -dix : dix) + (diy < 0 ? -diy : diy);
				lo = (dox < 0 ? -dox : dox) + (doy < 0 ? -doy : doy);
				r = rcap;
				if (li < r) r = li;
				if (lo < r) r = lo;
				if (r < RadMin) begin
					push_vertex(cx[i], cy[i]);
				end else begin
					c2x = 2 * cx[i]; c2y = 2 * cy[i];
					a2x = c2x - sgn(dix) * r; a2y = c2y - sgn(diy) * r;
					e2x = c2x + sgn(dox) * r; e2y = c2y + sgn(doy) * r;
					push_vertex(fshift(a2x + 1, 1), fshift(a2y + 1, 1));
					for (k = 0; k < 3; k++) begin
						bx = w0[k] * a2x + w1[k] * c2x + w2[k] * e2x;
						by = w0[k] * a2y + w1[k] * c2y + w2[k] * e2y;
						push_vertex(fshift(bx + 16, 5), fshift(by + 16, 5));
					end
					push_vertex(fshift(e2x + 1, 1), fshift(e2y + 1, 1));
				end
			end
			push_vertex(cx[nc-1], cy[nc-1]);
			v = pending.pop_back();
			v.lst = 1'b1;
			pending.push_back(v);
			wires++;
		endfunction

		function void check_vertex(logic signed [20:0] x, logic signed [20:0] y, logic l);
			vertex_t v;
			vertices++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected vertex x=%0d y=%0d last=%0b", $time, x, y, l);
				errors++;
				return;
			end
			v = pending.pop_front();
			if (v.x !== x || v.y !== y || v.lst !== l) begin
				$display("%0t: vertex mismatch expected x=%0d y=%0d last=%0b actual x=%0d y=%0d last=%0b",
					$time, v.x, v.y, v.lst, x, y, l);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [19:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [20:0] point_x, point_y;
	logic last;

	polyline_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycles = 0;
	localparam longint CycleLimit = 400000;

	orthogonal_wire_router_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Check vertices at the rising edge; pick the next ready level at the falling one.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_vertex(point_x, point_y, last);

	always @(negedge clk)
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic write_zoom(input logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 3'(4 * RegZoom); pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.zoom = value;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Called at a falling edge; returns at the falling edge after the beat, valid still high.
	task automatic send_wire(input logic [19:0] sx, sy, ex, ey);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
		do @(posedge clk); while (!in_ready);
		sb.note_wire(longint'(signed'(sx)), longint'(signed'(sy)),
			longint'(signed'(ex)), longint'(signed'(ey)));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Pins within 600 units per axis for half the wires, up to 4000 for a third, anywhere for the rest.
	task automatic random_wires(input int count);
		logic [19:0] sx, sy, ex, ey;
		for (int i = 0; i < count; i++) begin
			sx = $urandom; sy = $urandom;
			case ($urandom_range(5))
				0: begin ex = $urandom; ey = $urandom; end
				1: begin ex = sx + 20'($urandom_range(2000)); ey = sy + 20'($urandom_range(48)) - 20'd24; end
				2: begin ex = sx + 20'($urandom_range(4000)); ey = sy + 20'($urandom_range(4000)) - 20'd2000; end
				default: begin ex = sx + 20'($urandom_range(1200)) - 20'd600; ey = sy + 20'($urandom_range(1200)) - 20'd600; end
			endcase
			send_wire(sx, sy, ex, ey);
		end
	endtask

	initial begin
		logic [15:0] zooms[6];
		zooms = '{16'd4096, 16'd0, 16'd1, 16'd65535, 16'd2048, 16'd12000};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		out_ready <= 1'b1;

		// Directed: straight, level tolerance edges, elbow threshold, detours, extremes.
		send_wire(20'sd0, 20'sd0, 20'sd1600, 20'sd0);
		send_wire(20'sd0, 20'sd0, 20'sd1600, 20'sd24);
		send_wire(20'sd0, 20'sd0, 20'sd1600, -20'sd25);
		send_wire(20'sd0, 20'sd0, 20'sd448, 20'sd800);
		send_wire(20'sd0, 20'sd0, 20'sd447, 20'sd800);
		send_wire(20'sd100, 20'sd0, 20'sd0, 20'sd0);
		send_wire(20'sd0, 20'sd0, 20'sd0, 20'sd30);
		send_wire(20'sd0, 20'sd0, 20'sd300, 20'sd900);
		send_wire(20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF);
		send_wire(20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 20'sh80000);
		send_wire(20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh7FFFF);
		send_wire(20'sh80000, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000);
		send_wire(-20'sd5, -20'sd7, -20'sd3, 20'sd41);
		drain();
		write_zoom(16'd65535);
		send_wire(20'sd0, 20'sd0, 20'sd100, 20'sd5000);
		send_wire(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000);
		drain();
		write_zoom(16'd0);
		send_wire(20'sd0, 20'sd0, 20'sd0, 20'sd100);
		send_wire(20'sd0, 20'sd0, -20'sd10, 20'sd100);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 26 : ((ph == 1) ? 69 : 0);
			recv_idle_pct = (ph == 0) ? 69 : ((ph == 1) ? 26 : 0);
			for (int z = 0; z < 6; z++) begin
				write_zoom(zooms[(z + ph) % 6]);
				random_wires(18);
				drain();
			end
		end

		$display("Covered %0d wires and %0d vertices over six zoom settings and three idle mixes.",
			sb.wires, sb.vertices);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
